// ===== hw/rtl/gpioed_pkg.sv =====
package gpioed_pkg;

   // Request kinds carried in the request tuser.
   localparam logic [1:0] FUNC_READ   = 2'd0;
   localparam logic [1:0] FUNC_WRITE  = 2'd1;
   localparam logic [1:0] FUNC_SAMPLE = 2'd2;

   // Register word indexes (byte offset divided by four).
   localparam logic [5:0] W_FSEL_LAST = 6'd5;
   localparam logic [5:0] W_SET0      = 6'd7;
   localparam logic [5:0] W_SET1      = 6'd8;
   localparam logic [5:0] W_CLR0      = 6'd10;
   localparam logic [5:0] W_CLR1      = 6'd11;
   localparam logic [5:0] W_LEV0      = 6'd13;
   localparam logic [5:0] W_LEV1      = 6'd14;
   localparam logic [5:0] W_EDS0      = 6'd16;
   localparam logic [5:0] W_EDS1      = 6'd17;
   localparam logic [5:0] W_REN0      = 6'd19;
   localparam logic [5:0] W_REN1      = 6'd20;
   localparam logic [5:0] W_FEN0      = 6'd22;
   localparam logic [5:0] W_FEN1      = 6'd23;
   localparam logic [5:0] W_HEN0      = 6'd25;
   localparam logic [5:0] W_HEN1      = 6'd26;
   localparam logic [5:0] W_LEN0      = 6'd28;
   localparam logic [5:0] W_LEN1      = 6'd29;
   localparam logic [5:0] W_AREN0     = 6'd31;
   localparam logic [5:0] W_AREN1     = 6'd32;
   localparam logic [5:0] W_AFEN0     = 6'd34;
   localparam logic [5:0] W_AFEN1     = 6'd35;
   localparam logic [5:0] W_PUD       = 6'd37;
   localparam logic [5:0] W_PUDCLK0   = 6'd38;
   localparam logic [5:0] W_PUDCLK1   = 6'd39;

   // Function select layout: ten 3-bit fields per word, six words.
   localparam int FSEL_WORDS    = 6;
   localparam int PINS_PER_WORD = 10;
   localparam logic [2:0] FSEL_OUTPUT = 3'd1;

   // Pull state codes.
   localparam logic [1:0] PULL_DOWN = 2'd1;
   localparam logic [1:0] PULL_UP   = 2'd2;

   // Command fields of one request, as seen by the register file.
   typedef struct packed {
      logic [1:0]  func;
      logic [5:0]  word;
      logic [31:0] data;
   } gpioed_cmd_type;

endpackage

// ===== hw/rtl/gpioed_regfile.sv =====
module gpioed_regfile #(
   parameter int NUM_PINS = 54
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step_en,
   input  gpioed_pkg::gpioed_cmd_type    cmd,
   input  logic [NUM_PINS-1:0]           levels,
   output logic [31:0]                   read_data,
   output logic [NUM_PINS-1:0]           drive_level,
   output logic [NUM_PINS-1:0]           drive_enable,
   output logic [NUM_PINS-1:0]           pull_up_mask,
   output logic [NUM_PINS-1:0]           pull_down_mask,
   output logic                          irq
);

   typedef logic [NUM_PINS-1:0] pins_type;

   // Place a 32-bit bus word into the low or high half of the pin vector.
   function automatic pins_type widen(input logic [31:0] d, input logic hi);
      logic [63:0] v;
      v = hi ? {d, 32'h0} : {32'h0, d};
      return v[NUM_PINS-1:0];
   endfunction

   // Read one half of a pin vector; missing pins read as zero.
   function automatic logic [31:0] half_of(input pins_type r, input logic hi);
      logic [63:0] v;
      v = 64'(r);
      return hi ? v[63:32] : v[31:0];
   endfunction

   // Replace one half of a pin vector with a bus word.
   function automatic pins_type put_half(input pins_type r, input logic [31:0] d,
                                         input logic hi);
      logic [63:0] v;
      v = 64'(r);
      if (hi) begin
         v[63:32] = d;
      end else begin
         v[31:0] = d;
      end
      return v[NUM_PINS-1:0];
   endfunction

   // Bits of a function select word that belong to existing pins.
   function automatic logic [29:0] fsel_mask(input int w);
      logic [29:0] m;
      m = '0;
      for (int k = 0; k < gpioed_pkg::PINS_PER_WORD; k++) begin
         if (w * gpioed_pkg::PINS_PER_WORD + k < NUM_PINS) begin
            m[3*k +: 3] = 3'b111;
         end
      end
      return m;
   endfunction

   logic [29:0] fsel_ff [gpioed_pkg::FSEL_WORDS];
   logic [29:0] fsel_in [gpioed_pkg::FSEL_WORDS];
   pins_type    latch_ff, latch_in;
   pins_type    level_ff, level_in;
   pins_type    status_ff, status_in;
   pins_type    ren_ff, ren_in;
   pins_type    fen_ff, fen_in;
   pins_type    hen_ff, hen_in;
   pins_type    len_ff, len_in;
   pins_type    aren_ff, aren_in;
   pins_type    afen_ff, afen_in;
   pins_type    pull_hi_ff, pull_hi_in;
   pins_type    pull_lo_ff, pull_lo_in;
   logic [1:0]  pud_ff, pud_in;
   logic [31:0] pclk_ff [2];
   logic [31:0] pclk_in [2];

   logic        is_write;
   logic        hi;
   pins_type    wide;
   pins_type    rise, fall, events;

   assign is_write = (cmd.func == gpioed_pkg::FUNC_WRITE);
   assign wide     = widen(cmd.data, hi);

   // The second word of each pair addresses pins 32 and up.
   always_comb begin
      unique case (cmd.word)
         gpioed_pkg::W_SET1, gpioed_pkg::W_CLR1, gpioed_pkg::W_LEV1, gpioed_pkg::W_EDS1,
         gpioed_pkg::W_REN1, gpioed_pkg::W_FEN1, gpioed_pkg::W_HEN1, gpioed_pkg::W_LEN1,
         gpioed_pkg::W_AREN1, gpioed_pkg::W_AFEN1, gpioed_pkg::W_PUDCLK1: hi = 1'b1;
         default: hi = 1'b0;
      endcase
   end

   // Edge and level events seen on a sample tick.
   assign rise   = levels & ~level_ff;
   assign fall   = ~levels & level_ff;
   assign events = (rise & (ren_ff | aren_ff)) | (fall & (fen_ff | afen_ff))
                 | (levels & hen_ff) | (~levels & len_ff);

   // Next state for one request.
   always_comb begin
      for (int i = 0; i < gpioed_pkg::FSEL_WORDS; i++) begin
         fsel_in[i] = fsel_ff[i];
      end
      pclk_in[0] = pclk_ff[0];
      pclk_in[1] = pclk_ff[1];
      latch_in   = latch_ff;
      level_in   = level_ff;
      status_in  = status_ff;
      ren_in     = ren_ff;
      fen_in     = fen_ff;
      hen_in     = hen_ff;
      len_in     = len_ff;
      aren_in    = aren_ff;
      afen_in    = afen_ff;
      pull_hi_in = pull_hi_ff;
      pull_lo_in = pull_lo_ff;
      pud_in     = pud_ff;
      if (cmd.func == gpioed_pkg::FUNC_SAMPLE) begin
         level_in  = levels;
         status_in = status_ff | events;
      end else if (is_write) begin
         priority if (cmd.word <= gpioed_pkg::W_FSEL_LAST) begin
            fsel_in[cmd.word[2:0]] = cmd.data[29:0] & fsel_mask(int'(cmd.word));
         end else begin
            unique case (cmd.word)
               gpioed_pkg::W_SET0, gpioed_pkg::W_SET1: latch_in = latch_ff | wide;
               gpioed_pkg::W_CLR0, gpioed_pkg::W_CLR1: latch_in = latch_ff & ~wide;
               gpioed_pkg::W_EDS0, gpioed_pkg::W_EDS1: status_in = status_ff & ~wide;
               gpioed_pkg::W_REN0, gpioed_pkg::W_REN1:
                  ren_in = put_half(ren_ff, cmd.data, hi);
               gpioed_pkg::W_FEN0, gpioed_pkg::W_FEN1:
                  fen_in = put_half(fen_ff, cmd.data, hi);
               gpioed_pkg::W_HEN0, gpioed_pkg::W_HEN1:
                  hen_in = put_half(hen_ff, cmd.data, hi);
               gpioed_pkg::W_LEN0, gpioed_pkg::W_LEN1:
                  len_in = put_half(len_ff, cmd.data, hi);
               gpioed_pkg::W_AREN0, gpioed_pkg::W_AREN1:
                  aren_in = put_half(aren_ff, cmd.data, hi);
               gpioed_pkg::W_AFEN0, gpioed_pkg::W_AFEN1:
                  afen_in = put_half(afen_ff, cmd.data, hi);
               gpioed_pkg::W_PUD: pud_in = cmd.data[1:0];
               gpioed_pkg::W_PUDCLK0, gpioed_pkg::W_PUDCLK1: begin
                  // Selected pins latch the current pull control value.
                  pclk_in[hi] = cmd.data;
                  pull_hi_in = (pull_hi_ff & ~wide) | (wide & {NUM_PINS{pud_ff[1]}});
                  pull_lo_in = (pull_lo_ff & ~wide) | (wide & {NUM_PINS{pud_ff[0]}});
               end
               default: ;
            endcase
         end
      end
   end

   // Register read; reads change no state.
   always_comb begin
      read_data = '0;
      if (cmd.func == gpioed_pkg::FUNC_READ) begin
         priority if (cmd.word <= gpioed_pkg::W_FSEL_LAST) begin
            read_data = {2'b00, fsel_ff[cmd.word[2:0]]};
         end else begin
            unique case (cmd.word)
               gpioed_pkg::W_LEV0, gpioed_pkg::W_LEV1: read_data = half_of(level_ff, hi);
               gpioed_pkg::W_EDS0, gpioed_pkg::W_EDS1: read_data = half_of(status_ff, hi);
               gpioed_pkg::W_REN0, gpioed_pkg::W_REN1: read_data = half_of(ren_ff, hi);
               gpioed_pkg::W_FEN0, gpioed_pkg::W_FEN1: read_data = half_of(fen_ff, hi);
               gpioed_pkg::W_HEN0, gpioed_pkg::W_HEN1: read_data = half_of(hen_ff, hi);
               gpioed_pkg::W_LEN0, gpioed_pkg::W_LEN1: read_data = half_of(len_ff, hi);
               gpioed_pkg::W_AREN0, gpioed_pkg::W_AREN1: read_data = half_of(aren_ff, hi);
               gpioed_pkg::W_AFEN0, gpioed_pkg::W_AFEN1: read_data = half_of(afen_ff, hi);
               gpioed_pkg::W_PUD:     read_data = {30'h0, pud_ff};
               gpioed_pkg::W_PUDCLK0: read_data = pclk_ff[0];
               gpioed_pkg::W_PUDCLK1: read_data = pclk_ff[1];
               default:               read_data = '0;
            endcase
         end
      end
   end

   // Pin outputs as they stand after this request.
   for (genvar p = 0; p < NUM_PINS; p++) begin : g_pin
      if (p < gpioed_pkg::FSEL_WORDS * gpioed_pkg::PINS_PER_WORD) begin : g_fsel
         assign drive_enable[p] =
            (fsel_in[p / 10][3 * (p % 10) +: 3] == gpioed_pkg::FSEL_OUTPUT);
      end else begin : g_nofsel
         assign drive_enable[p] = 1'b0;
      end
   end

   assign drive_level    = latch_in;
   assign pull_up_mask   = pull_hi_in & ~pull_lo_in;
   assign pull_down_mask = pull_lo_in & ~pull_hi_in;
   assign irq            = |status_in;

   // State registers, updated once per request.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < gpioed_pkg::FSEL_WORDS; i++) begin
            fsel_ff[i] <= '0;
         end
         pclk_ff[0] <= '0;
         pclk_ff[1] <= '0;
         latch_ff   <= '0;
         level_ff   <= '0;
         status_ff  <= '0;
         ren_ff     <= '0;
         fen_ff     <= '0;
         hen_ff     <= '0;
         len_ff     <= '0;
         aren_ff    <= '0;
         afen_ff    <= '0;
         pull_hi_ff <= '0;
         pull_lo_ff <= '0;
         pud_ff     <= '0;
      end else if (step_en) begin
         for (int i = 0; i < gpioed_pkg::FSEL_WORDS; i++) begin
            fsel_ff[i] <= fsel_in[i];
         end
         pclk_ff[0] <= pclk_in[0];
         pclk_ff[1] <= pclk_in[1];
         latch_ff   <= latch_in;
         level_ff   <= level_in;
         status_ff  <= status_in;
         ren_ff     <= ren_in;
         fen_ff     <= fen_in;
         hen_ff     <= hen_in;
         len_ff     <= len_in;
         aren_ff    <= aren_in;
         afen_ff    <= afen_in;
         pull_hi_ff <= pull_hi_in;
         pull_lo_ff <= pull_lo_in;
         pud_ff     <= pud_in;
      end
   end

endmodule

// ===== hw/rtl/gpio_controller_with_edge_detect_top.sv =====
// Channel    Direction  Contents
// req        in         tuser: func; tdata: word_offset, write_data, pin_levels
// rsp        out        tdata: read_data, drive_level, drive_enable, pull masks, irq
//
// One request per cycle is accepted unless the result stalls; its result passes through
// the input register, then the result register, before it is valid and can be taken.
// Reset clears the valid flags and every pin state; results reflect state after the request.
// A stalled result holds in the result register while the input register still
// takes one more request; upstream stalls only when both are full.
module gpio_controller_with_edge_detect_top #(
   parameter int NUM_PINS = 54
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // Fields from bit 0: word_offset[6], write_data[32], pin_levels[NUM_PINS], zero fill.
   input  logic [((38 + NUM_PINS + 7) / 8) * 8 - 1:0] req_tdata,
   // Fields from bit 0: func[2].
   input  logic [1:0]           req_tuser,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // Fields from bit 0: read_data[32], drive_level, drive_enable, pull_up_mask,
   // pull_down_mask (NUM_PINS each), irq[1], zero fill.
   output logic [((33 + 4 * NUM_PINS + 7) / 8) * 8 - 1:0] rsp_tdata
);

   localparam int RSP_W = ((33 + 4 * NUM_PINS + 7) / 8) * 8;

   logic                       s1_valid_ff, s1_valid_in;
   gpioed_pkg::gpioed_cmd_type s1_cmd_ff;
   logic [NUM_PINS-1:0]        s1_levels_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]           rsp_data_ff, rsp_data_in;
   logic                       req_fire;
   logic                       adv;

   logic [31:0]                read_data;
   logic [NUM_PINS-1:0]        drive_level, drive_enable, pull_up_mask, pull_down_mask;
   logic                       irq;

   // Handshake: the input stage moves on when the result register is free.
   assign adv          = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready   = !s1_valid_ff || adv;
   assign req_fire     = req_tvalid && req_tready;
   assign s1_valid_in  = req_fire || (s1_valid_ff && !adv);
   assign rsp_valid_in = adv || (rsp_valid_ff && !rsp_tready);

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (req_fire) begin
         s1_cmd_ff.func <= req_tuser;
         s1_cmd_ff.word <= req_tdata[5:0];
         s1_cmd_ff.data <= req_tdata[37:6];
         s1_levels_ff   <= req_tdata[38 +: NUM_PINS];
      end
   end

   gpioed_regfile #(
      .NUM_PINS(NUM_PINS)
   ) u_regfile (
      .clock         (clock),
      .reset         (reset),
      .step_en       (adv),
      .cmd           (s1_cmd_ff),
      .levels        (s1_levels_ff),
      .read_data     (read_data),
      .drive_level   (drive_level),
      .drive_enable  (drive_enable),
      .pull_up_mask  (pull_up_mask),
      .pull_down_mask(pull_down_mask),
      .irq           (irq)
   );

   // Pack the result word.
   always_comb begin
      rsp_data_in = '0;
      rsp_data_in[31:0]                      = read_data;
      rsp_data_in[32 +: NUM_PINS]            = drive_level;
      rsp_data_in[32 + NUM_PINS +: NUM_PINS] = drive_enable;
      rsp_data_in[32 + 2 * NUM_PINS +: NUM_PINS] = pull_up_mask;
      rsp_data_in[32 + 3 * NUM_PINS +: NUM_PINS] = pull_down_mask;
      rsp_data_in[32 + 4 * NUM_PINS]         = irq;
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // The input stage refuses a request only while it holds one.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> s1_valid_ff)
      else $error("input stage stalled while empty");

   // Anything but a read returns zero read data.
   a_read_zero: assert property (@(posedge clock) disable iff (reset)
      (adv && s1_cmd_ff.func != gpioed_pkg::FUNC_READ) |=> (rsp_data_ff[31:0] == 32'h0))
      else $error("nonzero read data for a non-read request");

   // Only a bus write can clear the interrupt.
   a_irq_sticky: assert property (@(posedge clock) disable iff (reset)
      (adv && rsp_valid_ff && s1_cmd_ff.func != gpioed_pkg::FUNC_WRITE
       && rsp_data_ff[32 + 4 * NUM_PINS])
      |=> rsp_data_ff[32 + 4 * NUM_PINS])
      else $error("interrupt dropped without a write");

endmodule
